// ----- rtl/core/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Command frame deframer package
// Request types, role and error codes, and register reset values.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned HdrPatternWidth = 48;
  localparam int unsigned CfgIndexWidth   = 2;

  localparam logic [HdrPatternWidth-1:0] HdrPatternReset = 48'h0F0E0D0C0B0A;
  localparam logic [7:0]                 VersionReset    = 8'h02;
  localparam logic [7:0]                 EndMarkerReset  = 8'h18;

  localparam logic [CfgIndexWidth-1:0] CfgHeaderPattern = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgVersionValue  = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgEndMarker     = 2'd2;

  typedef enum logic [2:0] {
    RoleHeader  = 3'd0,
    RoleVersion = 3'd1,
    RoleCheck   = 3'd2,
    RoleLength  = 3'd3,
    RoleCmdType = 3'd4,
    RoleCommand = 3'd5,
    RoleEnd     = 3'd6,
    RoleDropped = 3'd7
  } role_e;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrHeader    = 3'd1,
    ErrTooShort  = 3'd2,
    ErrEndMarker = 3'd3,
    ErrVersion   = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    role_e       role;
    logic        frame_end;
    logic        frame_ok;
    err_e        error_code;
    logic [15:0] command_length;
  } out_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/core/cfd_front.sv -----
// ----------------------------------------------------------------------------
// Command frame deframer front end
// Holds the configuration and per-frame state, tags each byte with its role
// and forms the verdict on the final byte.
// ----------------------------------------------------------------------------
module cfd_front #(
  parameter int unsigned HEADER_BYTES = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [cfd_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [cfd_pkg::HdrPatternWidth-1:0]   cfg_data_i,
  input  logic                                  in_valid_i,
  input  cfd_pkg::in_req_t                      in_i,
  input  cfd_pkg::q_status_t                    q_status_i,
  output logic                                  push_o,
  output cfd_pkg::out_req_t                     push_data_o
);

  localparam logic [2:0]  HdrLast   = 3'(HEADER_BYTES - 1);
  localparam logic [15:0] PosVer    = 16'(HEADER_BYTES);
  localparam logic [15:0] PosChkEnd = 16'(HEADER_BYTES + 4);
  localparam logic [15:0] PosLenEnd = 16'(HEADER_BYTES + 6);
  localparam logic [15:0] PosType   = 16'(HEADER_BYTES + 7);
  localparam logic [15:0] PosMin    = 16'(HEADER_BYTES + 8);
  localparam logic [15:0] PosMax    = 16'hFFFF;

  logic [cfd_pkg::HdrPatternWidth-1:0] hdr_pattern_q;
  logic [7:0]  version_q;
  logic [7:0]  end_marker_q;

  logic [15:0] pos_q, pos_d;
  logic        hdr_fail_q, hdr_fail_d;
  logic        ver_fail_q, ver_fail_d;
  logic [15:0] len_q, len_d;

  logic        accept;
  logic [63:0] hdr_ext;
  logic [2:0]  hdr_sel;
  logic [7:0]  hdr_expect;
  cfd_pkg::role_e role;
  cfd_pkg::err_e  err;

  assign accept     = in_valid_i && !q_status_i.full;
  assign hdr_ext    = {{(64 - cfd_pkg::HdrPatternWidth){1'b0}}, hdr_pattern_q};
  assign hdr_sel    = HdrLast - pos_q[2:0];
  assign hdr_expect = hdr_ext[{hdr_sel, 3'b000} +: 8];

  always_comb begin
    hdr_fail_d = hdr_fail_q;
    ver_fail_d = ver_fail_q;
    len_d      = len_q;
    pos_d      = pos_q;
    err        = cfd_pkg::ErrNone;

    if (pos_q < PosVer) begin
      role = cfd_pkg::RoleHeader;
      if (in_i.data_byte != hdr_expect) hdr_fail_d = 1'b1;
    end else if (pos_q == PosVer) begin
      role = cfd_pkg::RoleVersion;
      if (in_i.data_byte != version_q) ver_fail_d = 1'b1;
    end else if (pos_q <= PosChkEnd) begin
      role = cfd_pkg::RoleCheck;
    end else if (pos_q <= PosLenEnd) begin
      role  = cfd_pkg::RoleLength;
      len_d = {len_q[7:0], in_i.data_byte};
    end else if (pos_q == PosType) begin
      role = cfd_pkg::RoleCmdType;
    end else if (pos_q == PosMax) begin
      role = cfd_pkg::RoleDropped;
    end else begin
      role = cfd_pkg::RoleCommand;
    end

    push_data_o.out_byte       = in_i.data_byte;
    push_data_o.frame_end      = 1'b0;
    push_data_o.frame_ok       = 1'b0;
    push_data_o.command_length = '0;

    if (in_i.last) begin
      role = cfd_pkg::RoleEnd;
      if (hdr_fail_d) begin
        err = cfd_pkg::ErrHeader;
      end else if (pos_q < PosMin) begin
        err = cfd_pkg::ErrTooShort;
      end else if (in_i.data_byte != end_marker_q) begin
        err = cfd_pkg::ErrEndMarker;
      end else if (ver_fail_d) begin
        err = cfd_pkg::ErrVersion;
      end
      push_data_o.frame_end = 1'b1;
      push_data_o.frame_ok  = (err == cfd_pkg::ErrNone);
      if (err == cfd_pkg::ErrNone && len_d != '0) begin
        push_data_o.command_length = len_d - 16'd1;
      end
      pos_d      = '0;
      hdr_fail_d = 1'b0;
      ver_fail_d = 1'b0;
      len_d      = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 16'd1;
    end

    push_data_o.role       = role;
    push_data_o.error_code = err;
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_fail_q <= 1'b0;
      ver_fail_q <= 1'b0;
      len_q      <= '0;
    end else if (accept) begin
      pos_q      <= pos_d;
      hdr_fail_q <= hdr_fail_d;
      ver_fail_q <= ver_fail_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pattern_q <= cfd_pkg::HdrPatternReset;
      version_q     <= cfd_pkg::VersionReset;
      end_marker_q  <= cfd_pkg::EndMarkerReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cfd_pkg::CfgHeaderPattern: hdr_pattern_q <= cfg_data_i;
        cfd_pkg::CfgVersionValue:  version_q     <= cfg_data_i[7:0];
        cfd_pkg::CfgEndMarker:     end_marker_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/cfd_queue.sv -----
// ----------------------------------------------------------------------------
// Command frame deframer queue
// Two-entry queue of tagged bytes between the front end and the output stage.
// ----------------------------------------------------------------------------
module cfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cfd_pkg::out_req_t  push_data_i,
  input  logic               pop_i,
  output cfd_pkg::out_req_t  pop_data_o,
  output cfd_pkg::q_status_t status_o
);

  cfd_pkg::out_req_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign pop_data_o      = mem_q[rd_ptr_q];
  assign status_o.full   = (count_q == 2'd2);
  assign status_o.empty  = (count_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/cfd_back.sv -----
// ----------------------------------------------------------------------------
// Command frame deframer output stage
// Drains the queue into the output register and holds it while stalled.
// ----------------------------------------------------------------------------
module cfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfd_pkg::q_status_t q_status_i,
  input  cfd_pkg::out_req_t  q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output cfd_pkg::out_req_t  out_o,
  input  logic               out_stall_i
);

  logic              out_valid_q;
  cfd_pkg::out_req_t out_q;

  assign pop_o       = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= q_data_i;
  end

endmodule

// ----- rtl/core/command_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// Command frame deframer
// Splits a byte-serial datagram into header, version, check, length, command
// type and command bytes, and gives a verdict on the final byte.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in      | input     | in_valid / in_stall | in_i  (data_byte, last)
//   out     | output    | out_valid/out_stall | out_o (byte, role, verdict)
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while out_stall is low; each byte is written into a
// queue entry and then into the output register. The two-entry queue between the front
// end and the output stage absorbs output stall until it fills, which raises in_stall.
// Reset is asynchronous and restores the register defaults and frame state.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module command_frame_deframer #(
  parameter int unsigned HEADER_BYTES = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cfd_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [cfd_pkg::HdrPatternWidth-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cfd_pkg::in_req_t                    in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cfd_pkg::out_req_t                   out_o
);

  cfd_pkg::q_status_t q_status;
  cfd_pkg::out_req_t  push_data;
  cfd_pkg::out_req_t  pop_data;
  logic               push;
  logic               pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;

  cfd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  cfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

  a_ok_matches_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.frame_ok ==
                     (out_o.frame_end && out_o.error_code == cfd_pkg::ErrNone)))
    else $error("frame_ok disagrees with error_code");

  a_end_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_o.role == cfd_pkg::RoleEnd) == out_o.frame_end))
    else $error("end role and frame_end disagree");

  a_mid_frame_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.frame_end) |->
      (out_o.command_length == '0 && out_o.error_code == cfd_pkg::ErrNone))
    else $error("verdict fields set before the final byte");

endmodule
